>>> rtl/ufold_pkg.sv
`timescale 1ns / 1ps
package ufold_pkg;

    localparam int GROUP_BYTES = 4;
    localparam int FOLD_ENTRIES = 67;

    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] CODE_LEAD2 = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] CODE_LEAD3 = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] CODE_LEAD4 = 8'hF0;

    typedef struct packed {
        logic [GROUP_BYTES-1:0][7:0] bytes;
        logic [2:0]                  count;
    } group_t;

    localparam logic [15:0] FOLD_CP [FOLD_ENTRIES] = '{
        16'h00E0, 16'h00E1, 16'h1EA3, 16'h00E3, 16'h1EA1,
        16'h0103, 16'h1EB1, 16'h1EAF, 16'h1EB3, 16'h1EB5, 16'h1EB7,
        16'h00E2, 16'h1EA7, 16'h1EA5, 16'h1EA9, 16'h1EAB, 16'h1EAD,
        16'h00E8, 16'h00E9, 16'h1EBB, 16'h1EBD, 16'h1EB9,
        16'h00EA, 16'h1EC1, 16'h1EBF, 16'h1EC3, 16'h1EC5, 16'h1EC7,
        16'h00EC, 16'h00ED, 16'h1EC9, 16'h0129, 16'h1ECB,
        16'h00F2, 16'h00F3, 16'h1ECF, 16'h00F5, 16'h1ECD,
        16'h00F4, 16'h1ED3, 16'h1ED1, 16'h1ED5, 16'h1ED7, 16'h1ED9,
        16'h01A1, 16'h1EDD, 16'h1EDB, 16'h1EDF, 16'h1EE1, 16'h1EE3,
        16'h00F9, 16'h00FA, 16'h1EE7, 16'h0169, 16'h1EE5,
        16'h01B0, 16'h1EEB, 16'h1EE9, 16'h1EED, 16'h1EEF, 16'h1EF1,
        16'h1EF3, 16'h00FD, 16'h1EF7, 16'h1EF9, 16'h1EF5,
        16'h0111
    };

    localparam logic [7:0] FOLD_LETTER [FOLD_ENTRIES] = '{
        8'h61, 8'h61, 8'h61, 8'h61, 8'h61,
        8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61,
        8'h61, 8'h61, 8'h61, 8'h61, 8'h61, 8'h61,
        8'h65, 8'h65, 8'h65, 8'h65, 8'h65,
        8'h65, 8'h65, 8'h65, 8'h65, 8'h65, 8'h65,
        8'h69, 8'h69, 8'h69, 8'h69, 8'h69,
        8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'h6F,
        8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'h6F,
        8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'h6F, 8'h6F,
        8'h75, 8'h75, 8'h75, 8'h75, 8'h75,
        8'h75, 8'h75, 8'h75, 8'h75, 8'h75, 8'h75,
        8'h79, 8'h79, 8'h79, 8'h79, 8'h79,
        8'h64
    };

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        if ((b & MASK_LEAD2) == CODE_LEAD2) len = 3'd2;
        else if ((b & MASK_LEAD3) == CODE_LEAD3) len = 3'd3;
        else if ((b & MASK_LEAD4) == CODE_LEAD4) len = 3'd4;
        else len = 3'd1;
        return len;
    endfunction

    function automatic logic [7:0] fold_ascii(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) r = b + 8'h20;
        return r;
    endfunction

    function automatic logic [7:0] lookup_letter(
        input logic [7:0] s0,
        input logic [7:0] s1,
        input logic [7:0] s2,
        input logic       is3
    );
        logic [15:0] cp;
        logic [15:0] up;
        logic        ok;
        logic [7:0]  letter;
        letter = 8'h00;
        if (is3)
        begin
            cp = {s0[3:0], s1[5:0], s2[5:0]};
            ok = (s1[7:6] == 2'b10) && (s2[7:6] == 2'b10) && (cp >= 16'h0800);
        end
        else
        begin
            cp = {5'd0, s0[4:0], s1[5:0]};
            ok = (s1[7:6] == 2'b10) && (cp >= 16'h0080);
        end
        for (int i = 0; i < FOLD_ENTRIES; i++)
        begin
            up = (FOLD_CP[i] < 16'h0100) ? FOLD_CP[i] - 16'h0020 : FOLD_CP[i] - 16'h0001;
            if (ok && (cp == FOLD_CP[i] || cp == up)) letter = FOLD_LETTER[i];
        end
        return letter;
    endfunction

endpackage

>>> rtl/ufold_front.sv
`timescale 1ns / 1ps
module ufold_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          text_byte,
    input  logic                text_end,
    output logic                push,
    output ufold_pkg::group_t   group
);

    logic [7:0] pend_reg [3];
    logic [1:0] cnt_reg, cnt_next;
    logic [2:0] exp_reg, exp_next;

    logic [7:0] buf_b [8];
    logic [2:0] n;
    logic [2:0] b_len;
    logic       emit;
    logic [2:0] pos;
    logic [2:0] k;
    logic [2:0] len;
    logic [7:0] letter;
    ufold_pkg::group_t grp;

    always_comb
    begin
        n = {1'b0, cnt_reg} + 3'd1;
        for (int j = 0; j < 8; j++)
        begin
            if (j < n - 3'd1) buf_b[j] = pend_reg[j[1:0]];
            else if (j == n - 3'd1) buf_b[j] = text_byte;
            else buf_b[j] = 8'h00;
        end
        b_len = ufold_pkg::lead_len(text_byte);
        emit = text_end || (n == 3'd1 && b_len == 3'd1) || (n >= 3'd2 && n >= exp_reg);

        pos = 3'd0;
        k = 3'd0;
        grp.bytes = '0;
        for (int s = 0; s < ufold_pkg::GROUP_BYTES; s++)
        begin
            if (pos < n)
            begin
                len = ufold_pkg::lead_len(buf_b[pos]);
                if (len > n - pos) len = 3'd1;
                letter = ufold_pkg::lookup_letter(buf_b[pos], buf_b[pos + 3'd1],
                                                  buf_b[pos + 3'd2], len == 3'd3);
                if (len == 3'd1)
                begin
                    grp.bytes[k[1:0]] = ufold_pkg::fold_ascii(buf_b[pos]);
                    k = k + 3'd1;
                end
                else if (len != 3'd4 && letter != 8'h00)
                begin
                    grp.bytes[k[1:0]] = letter;
                    k = k + 3'd1;
                end
                else
                begin
                    for (int j = 0; j < ufold_pkg::GROUP_BYTES; j++)
                    begin
                        if (j < len)
                        begin
                            grp.bytes[k[1:0]] = buf_b[pos + j[2:0]];
                            k = k + 3'd1;
                        end
                    end
                end
                pos = pos + len;
            end
            else
            begin
                len = 3'd0;
                letter = 8'h00;
            end
        end
        grp.count = k;

        cnt_next = cnt_reg;
        exp_next = exp_reg;
        if (accept)
        begin
            if (emit)
            begin
                cnt_next = 2'd0;
                exp_next = 3'd0;
            end
            else
            begin
                cnt_next = n[1:0];
                if (n == 3'd1) exp_next = b_len;
            end
        end
    end

    assign group = grp;
    assign push  = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            exp_reg <= 3'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            exp_reg <= exp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !emit) pend_reg[cnt_reg] <= text_byte;
    end

endmodule

>>> rtl/ufold_queue.sv
`timescale 1ns / 1ps
module ufold_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ufold_pkg::group_t   push_group,
    input  logic                pop,
    output ufold_pkg::group_t   head,
    output logic                empty,
    output logic                full
);

    ufold_pkg::group_t mem [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] fill_reg, fill_next;

    always_comb
    begin
        wr_next = push ? ~wr_reg : wr_reg;
        rd_next = pop ? ~rd_reg : rd_reg;
        fill_next = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    assign head  = mem[rd_reg];
    assign empty = (fill_reg == 2'd0);
    assign full  = (fill_reg == 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= 1'b0;
            rd_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem[wr_reg] <= push_group;
    end

endmodule

>>> rtl/ufold_back.sv
`timescale 1ns / 1ps
module ufold_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  ufold_pkg::group_t   head,
    input  logic                empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_byte,
    output logic                run_last
);

    logic [1:0] idx_reg, idx_next;
    logic       take;

    always_comb
    begin
        out_valid = !empty;
        out_byte  = head.bytes[idx_reg];
        run_last  = ({1'b0, idx_reg} == head.count - 3'd1);
        take      = out_valid && !out_stall;
        pop       = take && run_last;
        idx_next  = idx_reg;
        if (take) idx_next = run_last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) idx_reg <= 2'd0;
        else idx_reg <= idx_next;
    end

endmodule

>>> rtl/utf8_vietnamese_diacritic_fold_core.sv
`timescale 1ns / 1ps
// Folds a UTF-8 byte stream to plain lowercase text, one input word per cycle.
// Vietnamese accented letters become their base ASCII letter, A-Z become a-z,
// other sequences pass through. A byte that completes a sequence is written to
// the group queue; its output words appear in the cycle after at the earliest;
// output runs at one word per cycle while out_stall is low and a group waits.
// A flush at text_end can yield up to four words, absorbed by the two-entry group
// queue between the parser and output stage; input stalls only while it is full.
module utf8_vietnamese_diacritic_fold_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_stall,
    input  logic [7:0] text_byte,
    input  logic       text_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last
);

    ufold_pkg::group_t group;
    ufold_pkg::group_t head;
    logic push;
    logic pop;
    logic empty;
    logic full;
    logic accept;

    assign text_stall = full;
    assign accept     = text_valid && !full;

    ufold_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_byte (text_byte),
        .text_end  (text_end),
        .push      (push),
        .group     (group)
    );

    ufold_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (group),
        .pop        (pop),
        .head       (head),
        .empty      (empty),
        .full       (full)
    );

    ufold_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

endmodule

>>> bench/utf8_fold_checker.sv
`timescale 1ns / 1ps
module utf8_fold_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    input  logic       text_stall,
    input  logic [7:0] text_byte,
    input  logic       text_end,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_byte,
    input  logic       run_last,
    output int         fail_count,
    output int         words_owed
);

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } fold_word_t;

    fold_word_t  owed_words[$];
    logic [7:0]  held_bytes[3];
    int unsigned held_count;
    int unsigned seq_len;

    localparam logic [15:0] VIET_CP [67] = '{
        16'h00E0, 16'h00E1, 16'h1EA3, 16'h00E3, 16'h1EA1,
        16'h0103, 16'h1EB1, 16'h1EAF, 16'h1EB3, 16'h1EB5, 16'h1EB7,
        16'h00E2, 16'h1EA7, 16'h1EA5, 16'h1EA9, 16'h1EAB, 16'h1EAD,
        16'h00E8, 16'h00E9, 16'h1EBB, 16'h1EBD, 16'h1EB9,
        16'h00EA, 16'h1EC1, 16'h1EBF, 16'h1EC3, 16'h1EC5, 16'h1EC7,
        16'h00EC, 16'h00ED, 16'h1EC9, 16'h0129, 16'h1ECB,
        16'h00F2, 16'h00F3, 16'h1ECF, 16'h00F5, 16'h1ECD,
        16'h00F4, 16'h1ED3, 16'h1ED1, 16'h1ED5, 16'h1ED7, 16'h1ED9,
        16'h01A1, 16'h1EDD, 16'h1EDB, 16'h1EDF, 16'h1EE1, 16'h1EE3,
        16'h00F9, 16'h00FA, 16'h1EE7, 16'h0169, 16'h1EE5,
        16'h01B0, 16'h1EEB, 16'h1EE9, 16'h1EED, 16'h1EEF, 16'h1EF1,
        16'h1EF3, 16'h00FD, 16'h1EF7, 16'h1EF9, 16'h1EF5,
        16'h0111
    };

    function automatic int unsigned seq_length(logic [7:0] b);
        if (b[7:5] == 3'b110) return 2;
        if (b[7:4] == 4'b1110) return 3;
        if (b[7:3] == 5'b11110) return 4;
        return 1;
    endfunction

    function automatic logic [7:0] base_letter(int unsigned idx);
        if (idx < 17) return "a";
        if (idx < 28) return "e";
        if (idx < 33) return "i";
        if (idx < 50) return "o";
        if (idx < 61) return "u";
        if (idx < 66) return "y";
        return "d";
    endfunction

    function automatic logic [7:0] viet_letter(logic [7:0] s[4], int unsigned len);
        logic [31:0] cp;
        logic [31:0] lo;
        logic [31:0] up;
        if (len == 2)
        begin
            if (s[1][7:6] != 2'b10) return 8'h00;
            cp = {21'd0, s[0][4:0], s[1][5:0]};
            if (cp < 32'h80) return 8'h00;
        end
        else if (len == 3)
        begin
            if (s[1][7:6] != 2'b10 || s[2][7:6] != 2'b10) return 8'h00;
            cp = {16'd0, s[0][3:0], s[1][5:0], s[2][5:0]};
            if (cp < 32'h800) return 8'h00;
        end
        else
            return 8'h00;
        for (int i = 0; i < 67; i++)
        begin
            lo = {16'd0, VIET_CP[i]};
            up = (lo < 32'h100) ? lo - 32'h20 : lo - 32'h1;
            if (cp == lo || cp == up) return base_letter(i);
        end
        return 8'h00;
    endfunction

    task automatic owe_word(logic [7:0] value);
        fold_word_t w;
        w.value = value;
        w.last  = 1'b0;
        owed_words.insert(owed_words.size(), w);
    endtask

    task automatic fold_sequence(logic [7:0] s[4], int unsigned len);
        logic [7:0] letter;
        if (len == 1)
        begin
            letter = s[0];
            if (letter >= "A" && letter <= "Z") letter = letter + 8'h20;
            owe_word(letter);
            return;
        end
        letter = viet_letter(s, len);
        if (letter != 8'h00)
            owe_word(letter);
        else
            for (int i = 0; i < len; i++) owe_word(s[i]);
    endtask

    task automatic fold_byte(logic [7:0] b, logic last_of_text);
        logic [7:0]  buffer[4];
        logic [7:0]  piece[4];
        int unsigned n;
        int unsigned pos;
        int unsigned len;
        int unsigned before_count;
        before_count = owed_words.size();
        n = held_count;
        for (int i = 0; i < 4; i++) buffer[i] = 8'h00;
        for (int i = 0; i < n; i++) buffer[i] = held_bytes[i];
        buffer[n] = b;
        n++;
        if (last_of_text)
        begin
            pos = 0;
            while (pos < n)
            begin
                len = seq_length(buffer[pos]);
                if (len > n - pos) len = 1;
                for (int i = 0; i < 4; i++) piece[i] = (pos + i < 4) ? buffer[pos + i] : 8'h00;
                fold_sequence(piece, len);
                pos += len;
            end
            held_count = 0;
            seq_len = 0;
        end
        else if (n == 1)
        begin
            len = seq_length(b);
            if (len == 1)
                fold_sequence(buffer, 1);
            else
            begin
                held_bytes[0] = b;
                held_count = 1;
                seq_len = len;
            end
        end
        else if (n >= seq_len)
        begin
            fold_sequence(buffer, n);
            held_count = 0;
            seq_len = 0;
        end
        else
        begin
            held_bytes[n - 1] = b;
            held_count = n;
        end
        if (owed_words.size() > before_count)
            owed_words[owed_words.size() - 1].last = 1'b1;
    endtask

    fold_word_t head;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_words.delete();
            held_count = 0;
            seq_len = 0;
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_words.size() == 0)
                begin
                    $error("unexpected word: out_byte=%h run_last=%b", out_byte, run_last);
                    fail_count++;
                end
                else
                begin
                    head = owed_words.pop_front();
                    if (out_byte !== head.value)
                    begin
                        $error("out_byte expected %h actual %h", head.value, out_byte);
                        fail_count++;
                    end
                    if (run_last !== head.last)
                    begin
                        $error("run_last expected %b actual %b", head.last, run_last);
                        fail_count++;
                    end
                end
            end
            if (text_valid && !text_stall) fold_byte(text_byte, text_end);
        end
        words_owed = owed_words.size();
    end

endmodule

>>> bench/tb_utf8_vietnamese_diacritic_fold_core.sv
`timescale 1ns / 1ps
module tb_utf8_vietnamese_diacritic_fold_core;

    localparam int CYCLE_LIMIT = 200000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       text_valid = 1'b0;
    logic       text_stall;
    logic [7:0] text_byte = 8'h00;
    logic       text_end = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    int         fail_count;
    int         words_owed;
    int         cycle_count = 0;
    logic       calm = 1'b0;

    utf8_vietnamese_diacritic_fold_core dut
    (
        .clk(clk), .rst_n(rst_n),
        .text_valid(text_valid), .text_stall(text_stall),
        .text_byte(text_byte), .text_end(text_end),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_byte(out_byte), .run_last(run_last)
    );

    utf8_fold_checker checker_i
    (
        .clk(clk), .rst_n(rst_n),
        .text_valid(text_valid), .text_stall(text_stall),
        .text_byte(text_byte), .text_end(text_end),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_byte(out_byte), .run_last(run_last),
        .fail_count(fail_count), .words_owed(words_owed)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 35);

    task automatic send_word(logic [7:0] b, logic last_of_text);
        while (!calm && $urandom_range(99) < 35)
        begin
            text_valid <= 1'b0;
            @(negedge clk);
        end
        text_byte  <= b;
        text_end   <= last_of_text;
        text_valid <= 1'b1;
        @(posedge clk);
        while (text_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_letter(logic [15:0] cp, logic last_of_text);
        if (cp < 16'h0800)
        begin
            send_word({3'b110, cp[10:6]}, 1'b0);
            send_word({2'b10, cp[5:0]}, last_of_text);
        end
        else
        begin
            send_word({4'b1110, cp[15:12]}, 1'b0);
            send_word({2'b10, cp[11:6]}, 1'b0);
            send_word({2'b10, cp[5:0]}, last_of_text);
        end
    endtask

    task automatic send_random_sequence();
        int unsigned pick;
        int unsigned k;
        logic [15:0] cp;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            k = $urandom_range(66);
            cp = checker_i.VIET_CP[k];
            if ($urandom_range(1)) cp = (cp < 16'h100) ? cp - 16'h20 : cp - 16'h1;
            send_letter(cp, $urandom_range(9) == 0);
        end
        else if (pick < 55)
            send_word(8'($urandom_range(127)), $urandom_range(9) == 0);
        else if (pick < 70)
            send_letter(16'($urandom_range(16'h0080, 16'hFFFF)), $urandom_range(9) == 0);
        else if (pick < 80)
        begin
            send_word({5'b11110, 3'($urandom_range(7))}, 1'b0);
            k = $urandom_range(1, 3);
            for (int i = 0; i < k; i++)
                send_word({2'b10, 6'($urandom)}, (i == k - 1) && $urandom_range(1));
        end
        else if (pick < 90)
        begin
            send_word({3'b111, 5'($urandom)}, 1'b0);
            send_word(8'($urandom_range(255)), 1'b1);
        end
        else
            send_word(8'($urandom_range(255)), $urandom_range(3) == 0);
    endtask

    task automatic drain();
        while (words_owed != 0) @(posedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word("A", 1'b0);
        send_word("Z", 1'b0);
        send_word("@", 1'b0);
        send_word("[", 1'b0);
        send_letter(16'h00E0, 1'b0);
        send_letter(16'h00C0, 1'b0);
        send_letter(16'h0110, 1'b0);
        send_letter(16'h1EF9, 1'b0);
        send_letter(16'h1EF8, 1'b0);
        send_word(8'hC1, 1'b0);
        send_word(8'hA0, 1'b0);
        send_word(8'hC3, 1'b0);
        send_word(8'h41, 1'b0);
        send_word(8'hF0, 1'b0);
        send_word(8'h9F, 1'b0);
        send_word(8'h98, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hE1, 1'b0);
        send_word(8'hBA, 1'b1);
        send_word(8'hC3, 1'b1);
        send_word(8'hF0, 1'b0);
        send_word(8'hC3, 1'b0);
        send_word(8'hA0, 1'b1);
        text_valid <= 1'b0;

        drain();
        @(negedge clk);
        calm <= 1'b1;
        repeat (60) send_random_sequence();
        text_valid <= 1'b0;
        calm <= 1'b0;
        drain();
        repeat (4) @(posedge clk);
        @(negedge clk);
        repeat (121) send_random_sequence();
        send_word(8'h2E, 1'b1);
        text_valid <= 1'b0;

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/ufold_pkg.sv
rtl/ufold_front.sv
rtl/ufold_queue.sv
rtl/ufold_back.sv
rtl/utf8_vietnamese_diacritic_fold_core.sv
bench/utf8_fold_checker.sv
bench/tb_utf8_vietnamese_diacritic_fold_core.sv
